/* src/cbu_pkg.sv */
`timescale 1ns / 1ps

package cbu_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 6;

  localparam int TABLE_LEN     = 24;
  localparam int NUM_ITER      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int DIFF_W        = COORD_WIDTH + 1;
  localparam int PRESCALE_BITS = 24;
  localparam int GUARD_BITS    = 3;
  localparam int DATA_W        = DIFF_W + PRESCALE_BITS + GUARD_BITS;
  localparam int ANGLE_W       = 32;
  localparam int BEARING_W     = 15;

  localparam int UNITS   = 360 * (1 << ANGLE_FRAC_BITS);
  localparam int UNITS_W = $clog2(UNITS + 1);
  localparam int PROD_W  = ANGLE_W + UNITS_W;
  localparam int RES_W   = UNITS_W + 1;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] MINUS_QUARTER_TURN = 32'hC000_0000;
  localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(64'h8000_0000);

  localparam logic [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [ANGLE_W-1:0]       z;
    logic                     zero;
  } cbu_vec_t;

endpackage

/* src/compass_bearing_unit_core.sv */
// Compass bearing from a current position to a target position.
// Input channel: in_valid / in_stall with cur_x, cur_y, goal_x, goal_y as
// signed coordinates in one common length unit. A transfer happens at a
// rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with out_bearing, the bearing
// clockwise from north in 1/64 degree, 0 to 23039. Coincident positions
// give 90 degrees.
// Pipeline from an input transfer to out_valid: two front stages for
// difference and quadrant turn, one stage per CORDIC iteration, a
// multiply stage and an output register. Throughput: one item per cycle,
// set by the fully unrolled CORDIC pipeline, while out_stall is low.
// Reset (rst_n low, synchronous) empties every stage; no results remain.
// When the receiver stalls, the output holds and each stage keeps moving
// while the stage ahead of it is empty, so bubbles close up and new items
// are taken until the pipeline is full; only then does in_stall rise.
`timescale 1ns / 1ps

module compass_bearing_unit_core import cbu_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_cur_x,
  input  logic signed [COORD_WIDTH-1:0] in_cur_y,
  input  logic signed [COORD_WIDTH-1:0] in_goal_x,
  input  logic signed [COORD_WIDTH-1:0] in_goal_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [BEARING_W-1:0]          out_bearing
);

  logic     front_ready, cordic_ready, scale_ready;
  logic     front_valid, cordic_valid;
  cbu_vec_t front_vec, cordic_vec;

  cbu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cur_x     (in_cur_x),
    .cur_y     (in_cur_y),
    .goal_x    (in_goal_x),
    .goal_y    (in_goal_y),
    .up_ready  (front_ready),
    .vec_valid (front_valid),
    .vec       (front_vec),
    .dn_ready  (cordic_ready)
  );

  cbu_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_vec    (front_vec),
    .up_ready  (cordic_ready),
    .vec_valid (cordic_valid),
    .vec       (cordic_vec),
    .dn_ready  (scale_ready)
  );

  cbu_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cordic_valid),
    .in_vec      (cordic_vec),
    .up_ready    (scale_ready),
    .out_valid   (out_valid),
    .out_bearing (out_bearing),
    .out_stall   (out_stall)
  );

  assign in_stall = !front_ready;

endmodule

/* src/cbu_front.sv */
`timescale 1ns / 1ps

module cbu_front import cbu_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] cur_x,
  input  logic signed [COORD_WIDTH-1:0] cur_y,
  input  logic signed [COORD_WIDTH-1:0] goal_x,
  input  logic signed [COORD_WIDTH-1:0] goal_y,
  output logic                          up_ready,
  output logic                          vec_valid,
  output cbu_vec_t                      vec,
  input  logic                          dn_ready
);

  logic                     diff_valid_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic                     rot_valid_r;
  cbu_vec_t                 rot_r, rot_nxt;
  logic                     rdy_diff, rdy_rot;
  logic signed [DATA_W-1:0] xs, ys;

  assign rdy_rot  = !rot_valid_r || dn_ready;
  assign rdy_diff = !diff_valid_r || rdy_rot;
  assign up_ready = rdy_diff;

  assign dx_nxt = DIFF_W'(goal_x) - DIFF_W'(cur_x);
  assign dy_nxt = DIFF_W'(goal_y) - DIFF_W'(cur_y);

  assign xs = {{GUARD_BITS{dx_r[DIFF_W-1]}}, dx_r, {PRESCALE_BITS{1'b0}}};
  assign ys = {{GUARD_BITS{dy_r[DIFF_W-1]}}, dy_r, {PRESCALE_BITS{1'b0}}};

  always_comb begin
    rot_nxt.zero = (dx_r == '0) && (dy_r == '0);
    rot_nxt.x    = xs;
    rot_nxt.y    = ys;
    rot_nxt.z    = '0;
    if (xs[DATA_W-1]) begin
      if (!ys[DATA_W-1]) begin
        rot_nxt.x = ys;
        rot_nxt.y = -xs;
        rot_nxt.z = QUARTER_TURN;
      end else begin
        rot_nxt.x = -ys;
        rot_nxt.y = xs;
        rot_nxt.z = MINUS_QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_valid_r <= 1'b0;
      rot_valid_r  <= 1'b0;
    end else begin
      if (rdy_diff) diff_valid_r <= in_valid;
      if (rdy_rot)  rot_valid_r  <= diff_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_diff && in_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (rdy_rot && diff_valid_r) begin
      rot_r <= rot_nxt;
    end
  end

  assign vec_valid = rot_valid_r;
  assign vec       = rot_r;

endmodule

/* src/cbu_cordic.sv */
`timescale 1ns / 1ps

module cbu_cordic import cbu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  cbu_vec_t in_vec,
  output logic     up_ready,
  output logic     vec_valid,
  output cbu_vec_t vec,
  input  logic     dn_ready
);

  cbu_vec_t    v_r     [NUM_ITER];
  logic        valid_r [NUM_ITER];
  logic [NUM_ITER:0] rdy;

  assign rdy[NUM_ITER] = dn_ready;

  for (genvar k = 0; k < NUM_ITER; k++) begin : g_stage
    cbu_vec_t                 src;
    cbu_vec_t                 vec_nxt;
    logic                     src_valid;
    logic signed [DATA_W-1:0] xs, ys;

    if (k == 0) begin : g_first
      assign src       = in_vec;
      assign src_valid = in_valid;
    end else begin : g_next
      assign src       = v_r[k-1];
      assign src_valid = valid_r[k-1];
    end

    assign rdy[k] = !valid_r[k] || rdy[k+1];
    assign xs     = $signed(src.x) >>> k;
    assign ys     = $signed(src.y) >>> k;

    always_comb begin
      vec_nxt.zero = src.zero;
      if (!src.y[DATA_W-1]) begin
        vec_nxt.x = src.x + ys;
        vec_nxt.y = src.y - xs;
        vec_nxt.z = src.z + ATAN_TABLE[k];
      end else begin
        vec_nxt.x = src.x - ys;
        vec_nxt.y = src.y + xs;
        vec_nxt.z = src.z - ATAN_TABLE[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_valid) begin
        v_r[k] <= vec_nxt;
      end
    end
  end

  assign up_ready  = rdy[0];
  assign vec_valid = valid_r[NUM_ITER-1];
  assign vec       = v_r[NUM_ITER-1];

endmodule

/* src/cbu_scale.sv */
`timescale 1ns / 1ps

module cbu_scale import cbu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cbu_vec_t             in_vec,
  output logic                 up_ready,
  output logic                 out_valid,
  output logic [BEARING_W-1:0] out_bearing,
  input  logic                 out_stall
);

  logic                 mul_valid_r;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [ANGLE_W-1:0]   nav;
  logic                 out_valid_r;
  logic [BEARING_W-1:0] bearing_r, bearing_nxt;
  logic [PROD_W:0]      rounded;
  logic [RES_W-1:0]     res;
  logic                 rdy_mul, rdy_out;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy_mul  = !mul_valid_r || rdy_out;
  assign up_ready = rdy_mul;

  assign nav      = in_vec.zero ? QUARTER_TURN : (QUARTER_TURN - in_vec.z);
  assign prod_nxt = PROD_W'(nav) * PROD_W'(UNITS);

  assign rounded = {1'b0, prod_r} + ROUND_HALF;
  assign res     = rounded[PROD_W -: RES_W];

  always_comb begin
    if (res >= RES_W'(UNITS)) begin
      bearing_nxt = '0;
    end else begin
      bearing_nxt = BEARING_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_mul) mul_valid_r <= in_valid;
      if (rdy_out) out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_mul && in_valid) prod_r    <= prod_nxt;
    if (rdy_out && mul_valid_r) bearing_r <= bearing_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_bearing = bearing_r;

endmodule
